@@ src/ric_pkg.sv @@
// Shared types and codes for the reference-counted image cache table.
// No dependencies; used by ric_cell and the top level.
package ric_pkg;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_PURGE   = 2'd3;

  localparam logic [2:0] ST_MISS     = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_PARENT   = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NULL     = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  localparam logic [1:0] REG_CACHE_LIMIT = 2'd0;
  localparam logic [1:0] REG_TIMED_MODE  = 2'd1;
  localparam logic [1:0] REG_GRAD_MASK   = 2'd2;
  localparam logic [1:0] REG_PARENT_MASK = 2'd3;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [31:0] dims;
    logic [31:0] texture;
    logic [31:0] first_pix;
    logic [31:0] second_pix;
    logic [31:0] handle;
    logic [15:0] refs;
  } entry_t;

  // Broadcast controls seen by every cell; load_idx is compared inside the cell.
  typedef struct packed {
    logic        shift;
    logic        load;
    logic        dec;
    logic [31:0] rel_handle;
  } cell_ctrl_t;

endpackage

@@ src/refcounted_image_cache_table_core.sv @@
// Top level of the reference-counted image cache table: control sequencer and cell chain.
// Depends on ric_pkg and ric_cell.
//
// Channel   Dir  Handshake                 Words
// s_axis    in   s_axis_tvalid/tready      one operation per word
// m_axis    out  m_axis_tvalid/tready      one result word per operation
// cfg       in   cfg_valid_i/cfg_ready_o   one register write per word
//
// Lookups, purges and inserts that leave more entries than the limit walk the chain: the
// entries rotate through the head cell once, one entry a cycle, before the result is
// registered and the next word is accepted. Other inserts, releases with timed mode set,
// null words and parent-relative lookups go straight to the finish state. A release with
// timed mode clear walks the chain once, like a purge.
// Reset clears the fill count and the registers; entry contents are left as they are.
// A result waits in the output register while the next word is accepted and worked on;
// the next result is held back, and the input with it, until that register is free.
module refcounted_image_cache_table_core #(
  parameter int ENTRIES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: img_width[15:0], img_height[31:16], texture_word[63:32],
  //        first_pixel[95:64], second_pixel[127:96], handle_in[159:128]
  input  logic [159:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: handle_out[31:0], entries_in_use[38:32], zero fill [39]
  output logic [39:0]  m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import ric_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = ((CW > 7) ? CW : 7) + 1;

  typedef enum logic [1:0] {S_IDLE, S_ROTATE, S_FINISH} state_e;

  state_e      state_q;
  logic [CW-1:0] fill_q, steps_q;
  logic        lookup_q, found_q;
  logic [6:0]  limit_q;
  logic        timed_q;
  logic [31:0] grad_mask_q, parent_mask_q;
  logic [31:0] key_dims_q, key_tex_q, key_pix1_q, key_pix2_q;
  logic        key_grad_q;
  logic [2:0]  status_q;
  logic [31:0] hout_q;
  logic        out_valid_q;
  logic [2:0]  out_status_q;
  logic [31:0] out_hout_q;
  logic [6:0]  out_entries_q;

  // Unpacked input word.
  logic [1:0]  in_op;
  logic [31:0] in_dims, in_tex, in_pix1, in_pix2, in_handle;
  logic        in_grad, in_parent, in_accept;

  assign in_op     = s_axis_tuser;
  assign in_dims   = {s_axis_tdata[15:0], s_axis_tdata[31:16]};
  assign in_tex    = s_axis_tdata[63:32];
  assign in_pix1   = s_axis_tdata[95:64];
  assign in_pix2   = s_axis_tdata[127:96];
  assign in_handle = s_axis_tdata[159:128];
  assign in_grad   = (in_tex & grad_mask_q) != 32'd0;
  assign in_parent = (in_tex & parent_mask_q) != 32'd0;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Cell chain.
  entry_t     cells [ENTRIES];
  cell_ctrl_t ctrl;
  logic [IW-1:0] load_idx;
  entry_t     load_entry;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t next_e;
    if (g == ENTRIES - 1) begin : g_tail
      assign next_e = cells[g];
    end else begin : g_mid
      assign next_e = cells[g+1];
    end
    ric_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .load_idx_i   (load_idx),
      .load_entry_i (load_entry),
      .next_entry_i (next_e),
      .entry_o      (cells[g])
    );
  end

  // Head cell compare for the rotation pass.
  entry_t head, head_push;
  logic   head_match, head_keep, take_hit;

  assign head = cells[0];
  assign head_match = (head.dims == key_dims_q) && (head.texture == key_tex_q) &&
                      (head.first_pix == key_pix1_q) &&
                      (!key_grad_q || (head.second_pix == key_pix2_q));
  assign take_hit  = lookup_q && head_match && !found_q;
  assign head_keep = lookup_q || (head.refs != 16'd0);

  always_comb begin
    head_push = head;
    if (take_hit && (head.refs != REFS_MAX)) begin
      head_push.refs = head.refs + 16'd1;
    end
  end

  logic [MW-1:0] fill_plus;
  assign fill_plus = MW'(fill_q) + MW'(1);

  // Cell controls: an insert writes at the fill position, a release counts down matching
  // entries, a rotation step moves the head to the tail of the live region when it is kept.
  always_comb begin
    ctrl = '0;
    ctrl.rel_handle = in_handle;
    load_idx   = IW'(fill_q);
    load_entry = head_push;
    if (state_q == S_IDLE && in_accept) begin
      unique case (in_op)
        OP_INSERT: begin
          if (in_handle != 32'd0 && fill_q != CW'(ENTRIES)) begin
            ctrl.load = 1'b1;
          end
          load_entry.dims       = in_dims;
          load_entry.texture    = in_tex;
          load_entry.first_pix  = in_pix1;
          load_entry.second_pix = in_grad ? in_pix2 : 32'd0;
          load_entry.handle     = in_handle;
          load_entry.refs       = 16'd1;
        end
        OP_RELEASE: ctrl.dec = (in_handle != 32'd0);
        OP_LOOKUP, OP_PURGE: ;
        default: ;
      endcase
    end else if (state_q == S_ROTATE && steps_q != '0) begin
      ctrl.shift = 1'b1;
      ctrl.load  = head_keep;
      load_idx   = IW'(fill_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= 7'd64;
      timed_q       <= 1'b0;
      grad_mask_q   <= '0;
      parent_mask_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CACHE_LIMIT: limit_q       <= cfg_data_i[6:0];
        REG_TIMED_MODE:  timed_q       <= cfg_data_i[0];
        REG_GRAD_MASK:   grad_mask_q   <= cfg_data_i;
        REG_PARENT_MASK: parent_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      key_dims_q <= in_dims;
      key_tex_q  <= in_tex;
      key_pix1_q <= in_pix1;
      key_pix2_q <= in_pix2;
      key_grad_q <= in_grad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      fill_q        <= '0;
      steps_q       <= '0;
      lookup_q      <= 1'b0;
      found_q       <= 1'b0;
      status_q      <= ST_DONE;
      hout_q        <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_DONE;
      out_hout_q    <= '0;
      out_entries_q <= '0;
    end else begin
      // In the finish state the output register is handled below.
      if (out_valid_q && m_axis_tready && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            lookup_q <= (in_op == OP_LOOKUP) && !in_parent;
            found_q  <= 1'b0;
            unique case (in_op)
              OP_LOOKUP: begin
                hout_q  <= '0;
                steps_q <= fill_q;
                if (in_parent) begin
                  status_q <= ST_PARENT;
                  state_q  <= S_FINISH;
                end else begin
                  status_q <= ST_MISS;
                  state_q  <= S_ROTATE;
                end
              end
              OP_INSERT: begin
                if (in_handle == 32'd0) begin
                  status_q <= ST_NULL;
                  hout_q   <= '0;
                  steps_q  <= fill_q;
                  state_q  <= S_FINISH;
                end else if (fill_q == CW'(ENTRIES)) begin
                  status_q <= ST_FULL;
                  hout_q   <= '0;
                  steps_q  <= fill_q;
                  state_q  <= S_FINISH;
                end else begin
                  status_q <= ST_INSERTED;
                  hout_q   <= in_handle;
                  fill_q   <= CW'(fill_plus);
                  steps_q  <= CW'(fill_plus);
                  state_q  <= (fill_plus > MW'(limit_q)) ? S_ROTATE : S_FINISH;
                end
              end
              OP_RELEASE: begin
                hout_q   <= '0;
                steps_q  <= fill_q;
                status_q <= (in_handle == 32'd0) ? ST_NULL : ST_DONE;
                state_q  <= (in_handle != 32'd0 && !timed_q) ? S_ROTATE : S_FINISH;
              end
              OP_PURGE: begin
                hout_q   <= '0;
                steps_q  <= fill_q;
                status_q <= ST_DONE;
                state_q  <= S_ROTATE;
              end
              default: ;
            endcase
          end
        end
        S_ROTATE: begin
          if (steps_q == '0) begin
            state_q <= S_FINISH;
          end else begin
            steps_q <= steps_q - CW'(1);
            if (!head_keep) begin
              fill_q <= fill_q - CW'(1);
            end
            if (take_hit) begin
              found_q  <= 1'b1;
              status_q <= ST_HIT;
              hout_q   <= head.handle;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= status_q;
            out_hout_q    <= hout_q;
            out_entries_q <= 7'(fill_q);
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_entries_q, out_hout_q};
  assign m_axis_tuser  = out_status_q;

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(ENTRIES))
    else $error("fill count beyond table size");

  // During a rotation the remaining steps never exceed the live entries.
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROTATE) |-> (steps_q <= fill_q))
    else $error("rotation steps exceed fill count");

  // An insert into a full table leaves the fill count alone.
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_op == OP_INSERT && fill_q == CW'(ENTRIES)) |=> $stable(fill_q))
    else $error("dropped insert changed the fill count");

  // A lookup hit is taken at most once per pass.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROTATE && found_q) |-> !take_hit)
    else $error("second hit taken in one lookup");

endmodule

@@ src/ric_cell.sv @@
// One table entry of the cache chain: holds an entry and hands it to its left neighbour.
// Depends on ric_pkg.
module ric_cell #(
  parameter int IW = 6,
  parameter int IDX = 0
) (
  input  logic                clk_i,
  input  ric_pkg::cell_ctrl_t ctrl_i,
  input  logic [IW-1:0]       load_idx_i,
  input  ric_pkg::entry_t     load_entry_i,
  input  ric_pkg::entry_t     next_entry_i,
  output ric_pkg::entry_t     entry_o
);
  import ric_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load && (load_idx_i == IW'(IDX))) begin
      entry_d = load_entry_i;
    end else if (ctrl_i.shift) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.dec && (entry_q.handle == ctrl_i.rel_handle) &&
                 (entry_q.refs != 16'd0)) begin
      entry_d.refs = entry_q.refs - 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for refcounted_image_cache_table_core.
// Depends on ric_pkg and the core; drives operation words, checks every result word.
`timescale 1ns / 1ps

module testbench;
  import ric_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = OP_LOOKUP;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = REG_CACHE_LIMIT;
  logic [31:0]  cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  refcounted_image_cache_table_core #(.ENTRIES(DEPTH)) dut (.*);

  typedef struct {
    logic [1:0]  op;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] tex;
    logic [31:0] pix1;
    logic [31:0] pix2;
    logic [31:0] handle;
  } cache_op_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] handle;
    logic [6:0]  fill;
  } cache_res_t;

  // Shadow of the table, kept in insertion order.
  logic [31:0] sh_dims[DEPTH], sh_tex[DEPTH], sh_pix1[DEPTH], sh_pix2[DEPTH];
  logic [31:0] sh_handle[DEPTH];
  logic [15:0] sh_refs[DEPTH];
  int          sh_fill;
  logic [6:0]  lim_reg;
  logic        timed_reg;
  logic [31:0] grad_reg, parent_reg;

  cache_res_t  pending_results[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  logic [31:0] live_handles[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void compact_table();
    int wr;
    wr = 0;
    for (int rd = 0; rd < sh_fill; rd++) begin
      if (sh_refs[rd] != 0) begin
        sh_dims[wr] = sh_dims[rd]; sh_tex[wr] = sh_tex[rd];
        sh_pix1[wr] = sh_pix1[rd]; sh_pix2[wr] = sh_pix2[rd];
        sh_handle[wr] = sh_handle[rd]; sh_refs[wr] = sh_refs[rd];
        wr++;
      end
    end
    sh_fill = wr;
  endfunction

  function automatic cache_res_t predict_cache(input cache_op_t c);
    cache_res_t r;
    logic [31:0] dims;
    bit grad;
    dims = {c.w, c.h};
    grad = (c.tex & grad_reg) != 0;
    r.status = ST_DONE;
    r.handle = '0;
    case (c.op)
      OP_LOOKUP: begin
        if ((c.tex & parent_reg) != 0) r.status = ST_PARENT;
        else begin
          r.status = ST_MISS;
          for (int i = 0; i < sh_fill; i++) begin
            if (sh_dims[i] == dims && sh_tex[i] == c.tex && sh_pix1[i] == c.pix1 &&
                (!grad || sh_pix2[i] == c.pix2)) begin
              if (sh_refs[i] != REFS_MAX) sh_refs[i]++;
              r.status = ST_HIT;
              r.handle = sh_handle[i];
              break;
            end
          end
        end
      end
      OP_INSERT: begin
        if (c.handle == 0) r.status = ST_NULL;
        else if (sh_fill >= DEPTH) r.status = ST_FULL;
        else begin
          sh_dims[sh_fill] = dims; sh_tex[sh_fill] = c.tex; sh_pix1[sh_fill] = c.pix1;
          sh_pix2[sh_fill] = grad ? c.pix2 : '0;
          sh_handle[sh_fill] = c.handle; sh_refs[sh_fill] = 16'd1;
          sh_fill++;
          if (sh_fill > lim_reg) compact_table();
          r.status = ST_INSERTED;
          r.handle = c.handle;
        end
      end
      OP_RELEASE: begin
        if (c.handle == 0) r.status = ST_NULL;
        else begin
          for (int i = 0; i < sh_fill; i++)
            if (sh_handle[i] == c.handle && sh_refs[i] != 0) sh_refs[i]--;
          if (!timed_reg) compact_table();
        end
      end
      default: compact_table();
    endcase
    r.fill = 7'(sh_fill);
    return r;
  endfunction

  // Result checker; the receiver stalls at random and holds off on request.
  always @(posedge clk_i) begin
    cache_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result word", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) report("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[31:0] !== want.handle) report("handle", m_axis_tdata[31:0], want.handle);
        if (m_axis_tdata[38:32] !== want.fill)
          report("fill", 32'(m_axis_tdata[38:32]), 32'(want.fill));
      end
    end
    if (!rst_ni || hold_off) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 99) < 3) m_axis_tready <= 1'b0;
    else if (!m_axis_tready && $urandom_range(0, 9) < 3) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles with no accepted word of any kind.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_CACHE_LIMIT: lim_reg = val[6:0];
      REG_TIMED_MODE:  timed_reg = val[0];
      REG_GRAD_MASK:   grad_reg = val;
      default:         parent_reg = val;
    endcase
  endtask

  // Stops offering words, waits for all results, then lets a full rotation pass go by.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3 * DEPTH + 20) @(posedge clk_i);
  endtask

  task automatic send_op(input cache_op_t c, input bit check_fixed, input cache_res_t fixed);
    cache_res_t r;
    int gap;
    if ($urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {c.handle, c.pix2, c.pix1, c.tex, c.h, c.w};
    s_axis_tuser  <= c.op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_cache(c);
    if (check_fixed && (r.status !== fixed.status || r.fill !== fixed.fill))
      report("directed row status/fill", {r.status, 22'd0, r.fill}, {fixed.status, 22'd0, fixed.fill});
    pending_results = {pending_results, r};
    if (c.op == OP_INSERT && c.handle != 0) live_handles = {live_handles, c.handle};
  endtask

  function automatic cache_op_t mk(input logic [1:0] op, input logic [15:0] w,
      input logic [15:0] h, input logic [31:0] tex, input logic [31:0] p1,
      input logic [31:0] p2, input logic [31:0] hd);
    cache_op_t c;
    c.op = op; c.w = w; c.h = h; c.tex = tex; c.pix1 = p1; c.pix2 = p2; c.handle = hd;
    return c;
  endfunction

  // A key drawn from a small pool so that lookups hit often.
  function automatic cache_op_t rand_op(input logic [1:0] op);
    cache_op_t c;
    int k;
    k = $urandom_range(0, 7);
    c.op = op;
    if ($urandom_range(0, 9) == 0) begin
      c.w = 16'($urandom); c.h = 16'($urandom); c.tex = $urandom;
      c.pix1 = $urandom; c.pix2 = $urandom;
    end else begin
      c.w = 16'(k * 16); c.h = 16'hFFFF - 16'(k); c.tex = 32'h0000_0001 << (k % 4);
      c.pix1 = 32'h1111_1111 * k; c.pix2 = ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'h0;
    end
    if (op == OP_RELEASE && live_handles.size() != 0 && $urandom_range(0, 4) != 0)
      c.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
    else if ($urandom_range(0, 19) == 0) c.handle = '0;
    else c.handle = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(1, 40));
    return c;
  endfunction

  typedef struct {
    cache_op_t  c;
    bit         fixed;
    cache_res_t r;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    cache_res_t none;
    logic [1:0] op;
    int waited;
    none = '{status: ST_MISS, handle: '0, fill: '0};
    sh_fill = 0; lim_reg = 7'd64; timed_reg = 1'b0; grad_reg = '0; parent_reg = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: results after reset and the special cases read straight off.
    directed = '{
      '{mk(OP_LOOKUP, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1), 1, '{ST_MISS, '0, 7'd0}},
      '{mk(OP_INSERT, 0, 0, 0, 0, 0, 0), 1, '{ST_NULL, '0, 7'd0}},
      '{mk(OP_RELEASE, 0, 0, 0, 0, 0, 0), 1, '{ST_NULL, '0, 7'd0}},
      '{mk(OP_PURGE, 0, 0, 0, 0, 0, 0), 1, '{ST_DONE, '0, 7'd0}},
      '{mk(OP_INSERT, 16'hFFFF, 16'hFFFF, '1, '1, '1, '1), 1, '{ST_INSERTED, '1, 7'd1}},
      '{mk(OP_INSERT, 0, 0, 0, 0, 0, 32'h8000_0000), 1, '{ST_INSERTED, 0, 7'd2}},
      '{mk(OP_LOOKUP, 16'hFFFF, 16'hFFFF, '1, '1, 0, 0), 0, none},
      '{mk(OP_LOOKUP, 0, 0, 0, 0, '1, 0), 0, none},
      '{mk(OP_RELEASE, 0, 0, 0, 0, 0, 32'h1234), 1, '{ST_DONE, '0, 7'd2}},
      '{mk(OP_RELEASE, 0, 0, 0, 0, 0, '1), 0, none},
      '{mk(OP_RELEASE, 0, 0, 0, 0, 0, '1), 0, none},
      '{mk(OP_RELEASE, 0, 0, 0, 0, 0, '1), 0, none},
      '{mk(OP_LOOKUP, 0, 0, 0, 0, 0, 0), 0, none}
    };
    foreach (directed[i]) send_op(directed[i].c, directed[i].fixed, directed[i].r);
    drain();

    // Gradient and parent-relative keys, small limit, timed releases and a purge.
    // One entry survives the directed rows, so the fill starts at one.
    write_reg(REG_GRAD_MASK, 32'h0000_0002);
    write_reg(REG_PARENT_MASK, 32'h8000_0000);
    write_reg(REG_TIMED_MODE, 32'h1);
    write_reg(REG_CACHE_LIMIT, 32'h0);
    send_op(mk(OP_INSERT, 1, 2, 32'h2, 5, 6, 7), 1, '{ST_INSERTED, 32'd7, 7'd2});
    send_op(mk(OP_LOOKUP, 1, 2, 32'h2, 5, 9, 0), 1, '{ST_MISS, '0, 7'd2});
    send_op(mk(OP_LOOKUP, 1, 2, 32'h2, 5, 6, 0), 1, '{ST_HIT, 32'd7, 7'd2});
    send_op(mk(OP_LOOKUP, 1, 2, 32'h8000_0002, 5, 6, 0), 1, '{ST_PARENT, '0, 7'd2});
    send_op(mk(OP_INSERT, 3, 3, 32'h8000_0000, 1, 1, 9), 0, none);
    send_op(mk(OP_RELEASE, 0, 0, 0, 0, 0, 7), 0, none);
    send_op(mk(OP_RELEASE, 0, 0, 0, 0, 0, 7), 0, none);
    send_op(mk(OP_RELEASE, 0, 0, 0, 0, 0, 7), 0, none);
    send_op(mk(OP_PURGE, 0, 0, 0, 0, 0, 0), 0, none);
    drain();

    // Fill the table to the top with a large limit, then overflow it.
    write_reg(REG_CACHE_LIMIT, 32'h7F);
    for (int i = 0; i < DEPTH + 3; i++)
      send_op(mk(OP_INSERT, 16'(i), 0, 0, 32'(i), 0, 32'(100 + i)), 0, none);
    // Receiver holds off while the sender keeps offering lookups.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_op(mk(OP_LOOKUP, 16'(i), 0, 0, 32'(i), 0, 0), 0, none);
    join
    drain();

    // Random phases across several register settings.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_CACHE_LIMIT, (phase == 0) ? 32'd64 : (phase == 1) ? 32'd0 :
                32'($urandom_range(1, 64)));
      write_reg(REG_TIMED_MODE, 32'(phase % 2));
      write_reg(REG_GRAD_MASK, (phase == 2) ? '1 : 32'($urandom) & 32'h0000_000F);
      write_reg(REG_PARENT_MASK, (phase == 3) ? '1 : 32'($urandom_range(0, 1)) << 31);
      live_handles.delete();
      for (int n = 0; n < 170; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: op = OP_INSERT;
          4, 5, 6:    op = OP_LOOKUP;
          7, 8:       op = OP_RELEASE;
          default:    op = OP_PURGE;
        endcase
        send_op(rand_op(op), 0, none);
        if ($urandom_range(0, 29) == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(5, 30)) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (3 * DEPTH + 20) @(posedge clk_i);
    if (pending_results.size() != 0)
      report("results never arrived", 32'(pending_results.size()), 32'd0);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
